// ----- hdl/aes128_block_cipher_defines.svh -----
// ----------------------------------------------------------------------------
// AES-128 block cipher: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define AES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication: antecedent, then consequent by the given sequence
`define AES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`endif

// ----- hdl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-128 package
// Item types, register indexes, S-box tables and round transforms.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int unsigned ROUNDS_DEFAULT = 10;

  localparam logic [7:0] CFG_KEY_HIGH = 8'd0;
  localparam logic [7:0] CFG_KEY_LOW  = 8'd1;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of the state sits at bits 127-8k downwards; k = column*4 + row
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int k);
    get_byte = s[127 - 8*k -: 8];
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int k = 0; k < 16; k++) begin
      t[127 - 8*k -: 8] = inv ? INV_BOX[get_byte(s, k)] : FWD_BOX[get_byte(s, k)];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = inv ? get_byte(s, ((c - r + 4) & 3)*4 + r)
                                        : get_byte(s, ((c + r) & 3)*4 + r);
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = get_byte(s, c*4 + r);
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = xtime(a[r]) ^ xtime(a[(r+1)&3]) ^ a[(r+1)&3]
                                    ^ a[(r+2)&3] ^ a[(r+3)&3];
      end
    end
    mix_columns = t;
  endfunction

  // coefficients 14, 11, 13, 9: same map as three forward mixes
  function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = get_byte(s, c*4 + r);
        x2[r] = xtime(a[r]);
        x4[r] = xtime(x2[r]);
        x8[r] = xtime(x4[r]);
      end
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] =
            (x8[r] ^ x4[r] ^ x2[r])
          ^ (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3])
          ^ (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3])
          ^ (x8[(r+3)&3] ^ a[(r+3)&3]);
      end
    end
    inv_mix_columns = t;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/aes_kexp.sv -----
// ----------------------------------------------------------------------------
// AES key expansion
// Holds the key halves and steps the schedule one round key per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_kexp import aes_pkg::*; #(
  parameter int unsigned Rounds = ROUNDS_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic [7:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  output logic         busy_o,
  output logic [127:0] rk_o [Rounds+1]
);

  localparam int unsigned CntW = $clog2(Rounds + 1);

  logic [63:0]     key_hi_q, key_hi_d, key_lo_q, key_lo_d;
  logic            run_q, run_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      rc_q, rc_d;
  logic [127:0]    cur_q, cur_d;
  logic [127:0]    rk_q [1:Rounds];
  logic [127:0]    nxt;
  logic [31:0]     tw;
  logic            wr;

  assign wr = cfg_valid_i && (cfg_index_i == CFG_KEY_HIGH || cfg_index_i == CFG_KEY_LOW);

  always_comb begin
    tw = {FWD_BOX[cur_q[23:16]], FWD_BOX[cur_q[15:8]], FWD_BOX[cur_q[7:0]],
          FWD_BOX[cur_q[31:24]]} ^ {rc_q, 24'd0};
    nxt[127:96] = cur_q[127:96] ^ tw;
    nxt[95:64]  = cur_q[95:64] ^ nxt[127:96];
    nxt[63:32]  = cur_q[63:32] ^ nxt[95:64];
    nxt[31:0]   = cur_q[31:0] ^ nxt[63:32];
  end

  always_comb begin
    key_hi_d = key_hi_q;
    key_lo_d = key_lo_q;
    run_d    = run_q;
    cnt_d    = cnt_q;
    rc_d     = rc_q;
    cur_d    = cur_q;
    if (wr) begin
      if (cfg_index_i == CFG_KEY_HIGH) key_hi_d = cfg_data_i;
      else key_lo_d = cfg_data_i;
      run_d = 1'b1;
      cnt_d = CntW'(1);
      rc_d  = 8'h01;
      cur_d = {key_hi_d, key_lo_d};
    end else if (run_q) begin
      cur_d = nxt;
      rc_d  = xtime(rc_q);
      if (cnt_q == CntW'(Rounds)) run_d = 1'b0;
      else cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      run_q    <= 1'b1;   // expand the all-zero key after reset
      cnt_q    <= CntW'(1);
      rc_q     <= 8'h01;
      cur_q    <= '0;
    end else begin
      key_hi_q <= key_hi_d;
      key_lo_q <= key_lo_d;
      run_q    <= run_d;
      cnt_q    <= cnt_d;
      rc_q     <= rc_d;
      cur_q    <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q && !wr) rk_q[cnt_q] <= nxt;
  end

  assign rk_o[0] = {key_hi_q, key_lo_q};
  for (genvar i = 1; i <= Rounds; i++) begin : g_rk
    assign rk_o[i] = rk_q[i];
  end

  assign busy_o = run_q;

endmodule

`default_nettype wire

// ----- hdl/aes_round.sv -----
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher or inverse cipher round; direction travels with the item.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round import aes_pkg::*; #(
  parameter bit LastRound = 1'b0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic         mode_i,
  input  logic [127:0] state_i,
  input  logic [127:0] rk_i,
  output logic         valid_o,
  output logic         mode_o,
  output logic [127:0] state_o
);

  logic         valid_q;
  logic         mode_q;
  logic [127:0] state_q, state_d;
  logic [127:0] enc_t, dec_t;

  always_comb begin
    enc_t = shift_rows(sub_bytes(state_i, 1'b0), 1'b0);
    if (!LastRound) enc_t = mix_columns(enc_t);
    enc_t = enc_t ^ rk_i;
    // inverse round: key added before the inverse mix
    dec_t = sub_bytes(shift_rows(state_i, 1'b1), 1'b1) ^ rk_i;
    if (!LastRound) dec_t = inv_mix_columns(dec_t);
    state_d = mode_i ? dec_t : enc_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_i;
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  assign state_o = state_q;

endmodule

`default_nettype wire

// ----- hdl/aes128_block_cipher.sv -----
// ----------------------------------------------------------------------------
// AES-128 block cipher
// ECB encrypt/decrypt pipeline, one round per stage, with on-chip key schedule.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+--------------------------
//  input     | start, busy, in_i                         | taken when start & !busy
//  result    | done_o, result_o                          | one-cycle strobe, no stall
//  config    | cfg_valid_i, cfg_ready_o, cfg_index_i,    | valid & ready
//            | cfg_data_i                                |
//
// One item per cycle while busy is low; the pipeline holds the input key add
// stage plus one register stage per round.
// After reset and after every key write, the schedule makes the round keys, one
// per cycle; busy is high while it runs and no item is taken.
// The result side cannot stall, so the pipeline always advances.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_cipher import aes_pkg::*; #(
  parameter int unsigned Rounds = ROUNDS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  aes_in_t     in_i,
  output logic        done_o,
  output aes_out_t    result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  `include "aes128_block_cipher_defines.svh"

  logic [127:0] rk [Rounds+1];
  logic         v   [Rounds+1];
  logic         md  [Rounds+1];
  logic [127:0] st  [Rounds+1];
  logic         v0_q, md0_q;
  logic [127:0] st0_q;
  logic         acc;
  logic         key_wr;

  assign cfg_ready_o = 1'b1;

  aes_kexp #(.Rounds(Rounds)) u_kexp (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .busy_o (busy),
    .rk_o   (rk)
  );

  assign acc = start && !busy;

  assign key_wr = cfg_valid_i && cfg_ready_o
                  && (cfg_index_i == CFG_KEY_HIGH || cfg_index_i == CFG_KEY_LOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    md0_q <= in_i.mode;
    st0_q <= {in_i.block_high, in_i.block_low} ^ (in_i.mode ? rk[Rounds] : rk[0]);
  end

  assign v[0]  = v0_q;
  assign md[0] = md0_q;
  assign st[0] = st0_q;

  for (genvar k = 1; k <= Rounds; k++) begin : g_round
    logic [127:0] rks;
    assign rks = md[k-1] ? rk[Rounds-k] : rk[k];
    aes_round #(.LastRound(k == Rounds)) u_round (
      .clk_i, .rst_ni,
      .valid_i (v[k-1]),
      .mode_i  (md[k-1]),
      .state_i (st[k-1]),
      .rk_i    (rks),
      .valid_o (v[k]),
      .mode_o  (md[k]),
      .state_o (st[k])
    );
  end

  assign done_o   = v[Rounds];
  assign result_o = '{result_high: st[Rounds][127:64], result_low: st[Rounds][63:0]};

  `AES_ASSERT_IMP(a_latency, start && !busy, ##(Rounds+1) done_o, "item lost in pipeline")
  `AES_ASSERT_IMP(a_no_orphan, done_o, $past(start && !busy, Rounds+1), "result without item")
  `AES_ASSERT_IMP(a_key_busy, key_wr, ##1 busy, "key write did not start schedule")

endmodule

`default_nettype wire
